>>> sv/lkc_pkg.sv
package lkc_pkg;

    localparam int LKC_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic                    was_present;
        logic                    inserted;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
        logic [OCC_W-1:0]        occupancy;
    } t_out;

    typedef struct packed {
        logic load;
        logic hit_any;
        logic op_lookup;
        logic full;
    } t_cell_ctl;

endpackage

>>> sv/lkc_cell.sv
module lkc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lkc_pkg::t_cell_ctl        i_ctl,
    input  logic [lkc_pkg::KEY_W-1:0] i_key,
    input  logic [lkc_pkg::KEY_W-1:0] i_prev_key,
    input  logic                      i_prev_valid,
    input  logic                      i_hit_beyond,
    output logic [lkc_pkg::KEY_W-1:0] o_key,
    output logic                      o_valid,
    output logic                      o_hit_on
);
    import lkc_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_valid;
    logic             match;
    logic             shift;

    assign match    = r_valid && (r_key == i_key);
    assign o_hit_on = match | i_hit_beyond;

    // A lookup hit moves the entries in front of it back by one (an insert hit moves none);
    // a miss either fills the first free cell or drops the last valid one.
    always_comb begin
        if (i_ctl.hit_any) begin
            shift = i_ctl.load & i_ctl.op_lookup & o_hit_on;
        end else if (i_ctl.full) begin
            shift = i_ctl.load & r_valid;
        end else begin
            shift = i_ctl.load & i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_key <= i_prev_key;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

>>> sv/lru_key_cache.sv
// A transfer on the input gives its result in the output register in the next cycle.
// Throughput: one item per cycle unless stalled; all cells compare and shift together.
// The input stalls only while a finished result waits to be taken.
// Reset (synchronous, active low) clears the valid bits, the entry count and the
// output valid, and sets capacity to 16; stored keys are not cleared.
module lru_key_cache #(
    parameter int ENTRIES = lkc_pkg::LKC_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lkc_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lkc_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  logic [lkc_pkg::CAP_W-1:0] i_cfg_wdata
);
    import lkc_pkg::*;

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    logic [KEY_W-1:0] in_key;
    logic [KEY_W-1:0] c_key   [ENTRIES];
    logic             c_valid [ENTRIES];
    logic             c_hit   [ENTRIES];

    logic [CMPW-1:0]  cap_ext;
    logic [CMPW-1:0]  eff_cap;
    logic [CMPW-1:0]  cnt_ext;
    logic [CMPW-1:0]  occ_ext;
    logic [KEY_W-1:0] victim_key;
    logic             accept;
    t_cell_ctl        ctl;

    assign in_key     = i_in_data.key;
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    always_comb begin
        cap_ext = CMPW'(r_capacity);
        cnt_ext = CMPW'(r_count);
        if (cap_ext == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_ext > CMPW'(ENTRIES)) begin
            eff_cap = CMPW'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    always_comb begin
        ctl.load      = accept;
        ctl.hit_any   = c_hit[0];
        ctl.op_lookup = (i_in_data.operation == OP_LOOKUP);
        ctl.full      = (cnt_ext >= eff_cap);
    end

    generate
        for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
            logic [KEY_W-1:0] prev_key;
            logic             prev_valid;
            logic             hit_beyond;
            if (g == 0) begin : g_head
                assign prev_key   = in_key;
                assign prev_valid = 1'b1;
            end else begin : g_body
                assign prev_key   = c_key[g-1];
                assign prev_valid = c_valid[g-1];
            end
            if (g == ENTRIES - 1) begin : g_tail
                assign hit_beyond = 1'b0;
            end else begin : g_inner
                assign hit_beyond = c_hit[g+1];
            end
            lkc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_key        (in_key),
                .i_prev_key   (prev_key),
                .i_prev_valid (prev_valid),
                .i_hit_beyond (hit_beyond),
                .o_key        (c_key[g]),
                .o_valid      (c_valid[g]),
                .o_hit_on     (c_hit[g])
            );
        end
    endgenerate

    // The least recent entry is the last valid cell of the row.
    always_comb begin
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (c_valid[i] && (i == ENTRIES - 1 || !c_valid[(i + 1) % ENTRIES])) begin
                victim_key = victim_key | c_key[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        if (ctl.hit_any) begin
            n_out.was_present = 1'b1;
        end else begin
            n_out.inserted = 1'b1;
            if (ctl.full) begin
                n_out.evicted     = 1'b1;
                n_out.evicted_key = victim_key;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        occ_ext         = CMPW'(n_count);
        n_out.occupancy = occ_ext[OCC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (accept) begin
                r_count <= n_count;
            end
            r_out_valid <= accept | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/lkc_checker.sv
module lkc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lkc_pkg::t_out o_out_data
);
    import lkc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result changed.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("Accepted transfer gave no result on the next cycle.");

    a_hit_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.was_present |-> !o_out_data.inserted && !o_out_data.evicted)
        else $error("Hit reported together with an insertion.");

    a_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.evicted |-> o_out_data.evicted_key == '0)
        else $error("Evicted key is not zero without an eviction.");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("Input stalled while the output register is free.");

endmodule

bind lru_key_cache lkc_checker u_lkc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
